@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`endif

@@ design/bfia_pkg.sv @@
package bfia_pkg;

   localparam int unsigned ENTRIES_DEF  = 16;
   localparam int unsigned CAPACITY_DEF = 65536;
   localparam int unsigned CAP_BITS     = 25;
   localparam int unsigned SLOT_BITS    = 16;
   localparam int unsigned CNT_BITS     = 17;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_REJ  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic CMD_RESERVE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef logic [CAP_BITS-1:0] addr_type;

   typedef struct packed {
      logic     valid;
      addr_type start;
      addr_type len;
   } entry_type;

   localparam logic [1:0] OP_HOLD  = 2'd0;
   localparam logic [1:0] OP_SHL   = 2'd1;
   localparam logic [1:0] OP_SHR   = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic       wr;
      entry_type  wdata;
   } cell_ctrl_type;

endpackage

@@ design/bfia_cell.sv @@
module bfia_cell
   import bfia_pkg::*;
   (
      input  logic          clock,
      input  logic          reset,
      input  logic          is_head,
      input  logic          init_valid,
      input  addr_type      init_len,
      input  cell_ctrl_type ctrl,
      input  entry_type     left,
      input  entry_type     right,
      output entry_type     entry
   );

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_SHL: begin
            entry_in = right;
         end
         OP_SHR: begin
            entry_in = left;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      if (ctrl.wr) begin
         entry_in = ctrl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= init_valid;
         entry_ff.start <= '0;
         entry_ff.len   <= is_head ? init_len : '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ design/best_fit_interval_allocator_top.sv @@
// channel | ports                              | direction
// request | req_valid/ready, command, first_slot, count | in
// result  | rsp_valid/ready, reserved_start, status      | out
// A request scans the cell row one entry a cycle, then passes through the update
// state (S_ACT), then the result beat; no new request is taken before that.
// A rejected release is answered from idle with status REJ, without a scan.
// Insert and remove shift the entries from the affected index onward through neighbor links.
// Reset (synchronous) sets one free interval covering the whole space.
// A pending result holds in the output register; the next request waits for it.
`include "assert_macros.svh"
module best_fit_interval_allocator_top
   import bfia_pkg::*;
   #(
      parameter int unsigned ENTRIES  = ENTRIES_DEF,
      parameter int unsigned CAPACITY = CAPACITY_DEF
   )
   (
      input  logic                 clock,
      input  logic                 reset,
      input  logic                 req_valid,
      output logic                 req_ready,
      input  logic                 req_command,
      input  logic [SLOT_BITS-1:0] req_first_slot,
      input  logic [CNT_BITS-1:0]  req_count,
      output logic                 rsp_valid,
      input  logic                 rsp_ready,
      output logic [SLOT_BITS-1:0] rsp_reserved_start,
      output logic [1:0]           rsp_status
   );

   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam addr_type CAP = addr_type'(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_ACT  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmd_ff, cmd_in;
   addr_type      at_ff, at_in, n_ff, n_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   addr_type      bestlen_ff, bestlen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   entry_type     ent [ENTRIES];
   cell_ctrl_type ctl [ENTRIES];

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         entry_type lft, rgt;
         assign lft = (g == 0) ? entry_type'('0) : ent[(g == 0) ? 0 : g-1];
         assign rgt = (g == ENTRIES-1) ? entry_type'('0) :
                      ent[(g == ENTRIES-1) ? g : g+1];
         bfia_cell u_cell (
            .clock(clock), .reset(reset), .is_head(g == 0),
            .init_valid(g == 0), .init_len(CAP), .ctrl(ctl[g]),
            .left(lft), .right(rgt), .entry(ent[g])
         );
      end
   endgenerate

   // scan head: entry at idx, read through a mux
   entry_type cur, prv;
   logic [IW-1:0] idx_lo;
   logic          in_range;
   assign in_range = idx_ff < CW'(ENTRIES);
   assign idx_lo   = idx_ff[IW-1:0];
   assign cur = (in_range && ent[idx_lo].valid) ? ent[idx_lo] : entry_type'('0);
   assign prv = (idx_ff != '0) ? ent[IW'(idx_ff - CW'(1))] : entry_type'('0);

   logic          full;
   assign full = ent[ENTRIES-1].valid;

   addr_type cur_end, prv_end, top;
   assign cur_end = cur.start + cur.len;
   assign prv_end = prv.start + prv.len;
   assign top     = at_ff + n_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      at_in         = at_ff;
      n_in          = n_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bestlen_in    = bestlen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      for (int k = 0; k < ENTRIES; k++) begin
         ctl[k] = '{op: OP_HOLD, wr: 1'b0, wdata: entry_type'('0)};
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in   = req_command;
               at_in    = addr_type'(req_first_slot);
               n_in     = addr_type'(req_count);
               idx_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               bestlen_in = '0;
               state_in = S_SCAN;
               if (req_command == CMD_RELEASE && (req_count == '0 ||
                   addr_type'(req_first_slot) + addr_type'(req_count) > CAP)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_start_in  = '0;
                  rsp_status_in = ST_REJ;
                  state_in      = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            if (cmd_ff == CMD_RESERVE) begin
               if (in_range && cur.valid) begin
                  if (cur.len >= n_ff && (!found_ff || cur.len < bestlen_ff)) begin
                     found_in   = 1'b1;
                     best_in    = idx_lo;
                     bestlen_in = cur.len;
                  end
                  idx_in = idx_ff + CW'(1);
               end else begin
                  state_in = S_ACT;
               end
            end else begin
               if (in_range && cur.valid && cur_end <= at_ff) begin
                  idx_in = idx_ff + CW'(1);
               end else begin
                  state_in = S_ACT;
               end
            end
         end
         S_ACT: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_start_in  = '0;
            rsp_status_in = ST_OK;
            if (cmd_ff == CMD_RESERVE) begin
               if (!found_ff) begin
                  rsp_status_in = ST_NOFIT;
               end else begin
                  rsp_start_in = ent[best_ff].start[SLOT_BITS-1:0];
                  if (ent[best_ff].len == n_ff) begin
                     for (int k = 0; k < ENTRIES; k++) begin
                        if (k >= int'(best_ff)) ctl[k].op = OP_SHL;
                     end
                  end else begin
                     ctl[best_ff].wr = 1'b1;
                     ctl[best_ff].wdata = '{valid: 1'b1,
                        start: ent[best_ff].start + n_ff,
                        len: ent[best_ff].len - n_ff};
                  end
               end
            end else begin
               if (idx_ff != '0 && prv_end == at_ff && cur.valid &&
                   cur.start == top) begin
                  ctl[IW'(idx_ff - CW'(1))].wr = 1'b1;
                  ctl[IW'(idx_ff - CW'(1))].wdata = '{valid: 1'b1,
                     start: prv.start, len: prv.len + n_ff + cur.len};
                  for (int k = 0; k < ENTRIES; k++) begin
                     if (k >= int'(idx_ff)) ctl[k].op = OP_SHL;
                  end
               end else if (cur.valid && cur.start <= top) begin
                  ctl[idx_lo].wr = 1'b1;
                  ctl[idx_lo].wdata = '{valid: 1'b1, start: at_ff,
                     len: cur_end - at_ff};
               end else if (idx_ff != '0 && prv_end == at_ff) begin
                  ctl[IW'(idx_ff - CW'(1))].wr = 1'b1;
                  ctl[IW'(idx_ff - CW'(1))].wdata = '{valid: 1'b1,
                     start: prv.start, len: prv.len + n_ff};
               end else if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  for (int k = 0; k < ENTRIES; k++) begin
                     if (k > int'(idx_ff)) ctl[k].op = OP_SHR;
                  end
                  ctl[idx_lo].wr = 1'b1;
                  ctl[idx_lo].wdata = '{valid: 1'b1, start: at_ff, len: n_ff};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      at_ff         <= at_in;
      n_ff          <= n_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      bestlen_ff    <= bestlen_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready          = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reserved_start = rsp_start_ff;
   assign rsp_status         = rsp_status_ff;

   `ASSERT_IMPLIES(a_busy_no_ready, clock, reset, state_ff != S_IDLE, !req_ready)
   `ASSERT_IMPLIES(a_start_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_reserved_start == '0)
   `ASSERT_ALWAYS(a_head_valid_or_empty, clock, reset, ent[0].valid || !ent[1].valid)

endmodule
